// File: hw/rtl/lst_pkg.sv
// Shared types and constants for the sequential list store.
// No dependencies; every other file imports this package.
package lst_pkg;

  localparam int ACTION_BITS   = 3;
  localparam int POSITION_BITS = 5;
  localparam int VALUE_BITS    = 32;
  localparam int LENGTH_BITS   = 5;

  // Action codes
  localparam logic [ACTION_BITS-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_POP    = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_ERASE  = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_READ   = 3'd4;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 3'd5;

  // Result status codes
  localparam logic STAT_DONE     = 1'b0;
  localparam logic STAT_REJECTED = 1'b1;

  // Shift command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // open a gap at the slot and load the new word there
    logic era;  // close the gap at the slot from the right neighbor
  } lst_cmd_t;

endpackage

// File: hw/rtl/lst_if.sv
// Valid/ready channel interfaces for list requests and list results.
// Depends on lst_pkg for the field widths.
interface lst_req_if;
  import lst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_BITS-1:0]   action;
  logic [POSITION_BITS-1:0] position;
  logic [VALUE_BITS-1:0]    value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface lst_rsp_if;
  import lst_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [VALUE_BITS-1:0]  read_value;
  logic [LENGTH_BITS-1:0] length;
  logic                   is_empty;
  logic                   is_full;

  modport source (output valid, status, read_value, length, is_empty, is_full, input ready);
  modport sink   (input valid, status, read_value, length, is_empty, is_full, output ready);
endinterface

// File: hw/rtl/lst_cell.sv
// One storage cell of the list chain: holds a single entry and takes its
// neighbor's word on insert or erase. Depends on lst_pkg for lst_cmd_t.
module lst_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_BITS  = 4,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  lst_pkg::lst_cmd_t    cmd,
  input  logic [IDX_BITS-1:0]  slot,
  input  logic [WORD_BITS-1:0] new_word,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word
);
  import lst_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(INDEX);

  // Load at the slot, shift up above it on insert, shift down on erase
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_INDEX == slot) begin
        word <= new_word;
      end else if (MY_INDEX > slot) begin
        word <= left_word;
      end
    end else if (cmd.era && (MY_INDEX >= slot)) begin
      word <= right_word;
    end
  end

endmodule

// File: hw/rtl/sequential_list_store.sv
// The result beat is registered in the cycle after its request beat is accepted.
// Throughput: one request per cycle while results are taken; the whole
//   chain of cells shifts in parallel in the cycle the request is accepted.
// Reset: clears the entry count and the result valid; cell contents are
//   not reset and are never read before they are written.
module sequential_list_store #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  lst_req_if.sink   req,
  lst_rsp_if.source rsp
);
  import lst_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS = ((CNT_BITS > POSITION_BITS) ? CNT_BITS : POSITION_BITS) + 1;
  localparam logic [CMP_BITS-1:0] DEPTH_C = CMP_BITS'(DEPTH);

  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic                 accept;
  logic                 status_next;
  logic                 rd_en;
  logic [IDX_BITS-1:0]  rd_idx;
  logic [IDX_BITS-1:0]  slot;
  lst_cmd_t             cmd_raw;
  lst_cmd_t             cmd;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [63:0]          value_wide;
  logic [63:0]          rd_wide;
  logic [CMP_BITS-1:0]  pos_c;
  logic [CMP_BITS-1:0]  cnt_c;
  logic                 list_full;
  logic                 list_empty;
  logic                 pos_bad;
  logic [WORD_BITS-1:0] cell_word [DEPTH];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Fit the incoming word to the entry width
  assign value_wide = 64'(req.value);
  assign new_word   = value_wide[WORD_BITS-1:0];

  assign pos_c      = CMP_BITS'(req.position);
  assign cnt_c      = CMP_BITS'(count);
  assign list_full  = (cnt_c == DEPTH_C);
  assign list_empty = (count == '0);
  assign pos_bad    = (pos_c == '0) || (pos_c > cnt_c);

  // Decode the action into a shift command, a read index and the new count
  always_comb begin
    cmd_raw     = '0;
    slot        = '0;
    rd_en       = 1'b0;
    rd_idx      = '0;
    status_next = STAT_DONE;
    count_next  = count;
    case (req.action)
      ACT_PUSH: begin
        if (list_full) begin
          status_next = STAT_REJECTED;
        end else begin
          cmd_raw.ins = 1'b1;
          slot        = IDX_BITS'(count);
          count_next  = count + 1'b1;
        end
      end
      ACT_POP: begin
        if (list_empty) begin
          status_next = STAT_REJECTED;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = IDX_BITS'(count - 1'b1);
          count_next = count - 1'b1;
        end
      end
      ACT_INSERT: begin
        if ((pos_c == '0) || list_full) begin
          status_next = STAT_REJECTED;
        end else begin
          cmd_raw.ins = 1'b1;
          slot        = ((pos_c - 1'b1) < cnt_c) ? IDX_BITS'(pos_c - 1'b1)
                                                 : IDX_BITS'(count);
          count_next  = count + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (pos_bad) begin
          status_next = STAT_REJECTED;
        end else begin
          cmd_raw.era = 1'b1;
          slot        = IDX_BITS'(pos_c - 1'b1);
          count_next  = count - 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_bad) begin
          status_next = STAT_REJECTED;
        end else begin
          rd_en  = 1'b1;
          rd_idx = IDX_BITS'(pos_c - 1'b1);
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = STAT_REJECTED;
      end
    endcase
  end

  assign cmd.ins = cmd_raw.ins && accept;
  assign cmd.era = cmd_raw.era && accept;

  // Chain of cells wired to their neighbors; the left end is fed zero, the right end its own word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_word;
    logic [WORD_BITS-1:0] right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
    end else begin : g_mid_r
      assign right_word = cell_word[i+1];
    end
    lst_cell #(
      .INDEX     (i),
      .IDX_BITS  (IDX_BITS),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (slot),
      .new_word   (new_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (cell_word[i])
    );
  end

  // Pick the popped or read entry before the chain moves
  assign rd_word = rd_en ? cell_word[rd_idx] : '0;
  assign rd_wide = 64'(rd_word);

  // Advance the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= status_next;
      rsp.read_value <= rd_wide[VALUE_BITS-1:0];
      rsp.length     <= LENGTH_BITS'(count_next);
      rsp.is_empty   <= (count_next == '0);
      rsp.is_full    <= (CMP_BITS'(count_next) == DEPTH_C);
    end
  end

`ifndef SYNTHESIS
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.era))
    else $error("insert and erase issued together");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_BITS'(count) <= DEPTH_C)
    else $error("entry count above capacity");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next == STAT_REJECTED)) |=> (count == $past(count)))
    else $error("rejected action changed the count");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == ACT_CLEAR)) |=>
      (rsp.valid && (rsp.length == '0) && rsp.is_empty && (rsp.status == STAT_DONE)))
    else $error("clear did not report an empty list");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for sequential_list_store: a shadow list predicts every result beat.
// Depends on lst_pkg, lst_req_if / lst_rsp_if and the sequential_list_store RTL.
`timescale 1ns / 1ps

module tb_top;
  import lst_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 300000;

  // Action codes the block does not define; both must be rejected
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED_7 = 3'd7;

  // Traffic modes for the random stretches
  typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} traffic_mode_t;

  typedef struct {
    logic                   status;
    logic [VALUE_BITS-1:0]  read_value;
    logic [LENGTH_BITS-1:0] length;
    logic                   is_empty;
    logic                   is_full;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  lst_req_if req_ch();
  lst_rsp_if rsp_ch();

  sequential_list_store #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(VALUE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the list and the queue of results still to arrive
  logic [VALUE_BITS-1:0] shadow_entries [LIST_DEPTH];
  int                    shadow_count;
  list_result_t          awaited_results [$];
  int                    error_count;
  int                    cycle_count;
  bit                    steady;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Apply one action to the shadow list and return the result it must produce
  function automatic list_result_t apply_list_action(logic [ACTION_BITS-1:0] action,
                                                     logic [POSITION_BITS-1:0] position,
                                                     logic [VALUE_BITS-1:0] value);
    list_result_t r;
    int pos;
    int slot;
    pos = int'(position);
    r.status = STAT_DONE;
    r.read_value = '0;
    case (action)
      ACT_PUSH: begin
        if (shadow_count >= LIST_DEPTH) r.status = STAT_REJECTED;
        else begin
          shadow_entries[shadow_count] = value;
          shadow_count++;
        end
      end
      ACT_POP: begin
        if (shadow_count == 0) r.status = STAT_REJECTED;
        else begin
          shadow_count--;
          r.read_value = shadow_entries[shadow_count];
        end
      end
      ACT_INSERT: begin
        if (pos == 0 || shadow_count >= LIST_DEPTH) r.status = STAT_REJECTED;
        else begin
          // past the end means append
          slot = (pos - 1 < shadow_count) ? pos - 1 : shadow_count;
          for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot] = value;
          shadow_count++;
        end
      end
      ACT_ERASE: begin
        if (pos == 0 || pos > shadow_count) r.status = STAT_REJECTED;
        else begin
          for (int i = pos; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
          shadow_count--;
        end
      end
      ACT_READ: begin
        if (pos == 0 || pos > shadow_count) r.status = STAT_REJECTED;
        else r.read_value = shadow_entries[pos-1];
      end
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        r.status = STAT_REJECTED;
      end
    endcase
    r.length   = LENGTH_BITS'(shadow_count);
    r.is_empty = (shadow_count == 0);
    r.is_full  = (shadow_count == LIST_DEPTH);
    return r;
  endfunction

  // Send one request beat, record its prediction on acceptance, then idle a while
  task automatic send_item(logic [ACTION_BITS-1:0] action, logic [POSITION_BITS-1:0] position,
                           logic [VALUE_BITS-1:0] value);
    int gap;
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.action   <= action;
    req_ch.position <= position;
    req_ch.value    <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_results.insert(awaited_results.size(), apply_list_action(action, position, value));
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      // drop valid and put noise on the payload while idle
      @(negedge clk);
      req_ch.valid    <= 1'b0;
      req_ch.action   <= ACTION_BITS'($urandom);
      req_ch.position <= POSITION_BITS'($urandom);
      req_ch.value    <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic check_field(string name, logic [VALUE_BITS-1:0] expected,
                             logic [VALUE_BITS-1:0] actual);
    if (expected !== actual) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
      error_count++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no request outstanding");
        error_count++;
      end else begin
        exp_r = awaited_results.pop_front();
        check_field("status", exp_r.status, rsp_ch.status);
        check_field("read_value", exp_r.read_value, rsp_ch.read_value);
        check_field("length", exp_r.length, rsp_ch.length);
        check_field("is_empty", exp_r.is_empty, rsp_ch.is_empty);
        check_field("is_full", exp_r.is_full, rsp_ch.is_full);
      end
    end
  end

  // Stall the result side at random unless a steady stretch is running
  initial begin : result_stall_driver
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        rsp_ch.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog on total run length
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Position: mostly valid for the current length, some zero, past the end or out of range
  function automatic logic [POSITION_BITS-1:0] pick_position(logic [ACTION_BITS-1:0] action);
    int r;
    int top;
    r = $urandom_range(0, 99);
    top = (action == ACT_INSERT) ? shadow_count + 1 : shadow_count;
    if (top < 1) top = 1;
    if (top > LIST_DEPTH) top = LIST_DEPTH;
    if (r < 8) return '0;
    if (r < 12) return POSITION_BITS'($urandom_range(LIST_DEPTH + 1, 31));
    if (r < 22) return POSITION_BITS'($urandom_range(top, LIST_DEPTH));
    return POSITION_BITS'($urandom_range(1, top));
  endfunction

  function automatic logic [ACTION_BITS-1:0] pick_action(traffic_mode_t mode);
    int r;
    int add_weight;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   add_weight = 70;
      MODE_SHRINK: add_weight = 15;
      default:     add_weight = 40;
    endcase
    if (r < 2) return $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
    if (r < 4) return ACT_CLEAR;
    if (r < 4 + add_weight) return $urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT;
    case ($urandom_range(0, 2))
      0:       return ACT_POP;
      1:       return ACT_ERASE;
      default: return ACT_READ;
    endcase
  endfunction

  // Rejections on an empty list and the undefined action codes
  task automatic test_empty_rejections();
    send_item(ACT_POP, 5'd0, '0);
    send_item(ACT_READ, 5'd1, '0);
    send_item(ACT_ERASE, 5'd1, '1);
    send_item(ACT_INSERT, 5'd0, 32'h1234_5678);
    send_item(ACT_UNUSED_6, 5'd1, 32'hDEAD_BEEF);
    send_item(ACT_UNUSED_7, 5'd31, '1);
    send_item(ACT_CLEAR, 5'd0, '0);
  endtask

  // Insert, erase and read at the edges of the list
  task automatic test_edit_positions();
    send_item(ACT_PUSH, 5'd0, '1);
    send_item(ACT_INSERT, 5'd1, '0);
    send_item(ACT_INSERT, 5'd16, 32'hA5A5_5A5A);
    send_item(ACT_INSERT, 5'd31, 32'h5A5A_A5A5);
    send_item(ACT_INSERT, 5'd2, 32'h0F0F_F0F0);
    send_item(ACT_READ, 5'd1, '0);
    send_item(ACT_READ, 5'd5, '0);
    send_item(ACT_READ, 5'd6, '0);
    send_item(ACT_READ, 5'd0, '0);
    send_item(ACT_ERASE, 5'd0, '0);
    send_item(ACT_ERASE, 5'd6, '0);
    send_item(ACT_ERASE, 5'd3, '0);
    send_item(ACT_ERASE, 5'd1, '0);
    send_item(ACT_POP, 5'd0, '0);
    send_item(ACT_READ, 5'd2, '0);
    send_item(ACT_CLEAR, 5'd0, '0);
    send_item(ACT_READ, 5'd1, '0);
  endtask

  // Fill to capacity with random content, hit every full-list case, then drain
  task automatic test_full_boundary();
    send_item(ACT_CLEAR, 5'd0, '0);
    while (shadow_count < LIST_DEPTH) begin
      if ($urandom_range(0, 1)) send_item(ACT_PUSH, pick_position(ACT_PUSH), pick_value());
      else send_item(ACT_INSERT, pick_position(ACT_INSERT), pick_value());
    end
    send_item(ACT_PUSH, 5'd0, pick_value());
    send_item(ACT_INSERT, 5'd1, pick_value());
    send_item(ACT_INSERT, 5'd0, pick_value());
    send_item(ACT_INSERT, 5'd31, pick_value());
    send_item(ACT_READ, 5'd16, '0);
    send_item(ACT_READ, 5'd17, '0);
    send_item(ACT_ERASE, 5'd16, '0);
    send_item(ACT_INSERT, 5'd16, pick_value());
    send_item(ACT_READ, 5'd16, '0);
    send_item(ACT_POP, 5'd0, '0);
    while (shadow_count > 0) begin
      if ($urandom_range(0, 2) == 0) send_item(ACT_POP, 5'd0, pick_value());
      else send_item(ACT_ERASE, pick_position(ACT_ERASE), pick_value());
    end
    send_item(ACT_POP, 5'd0, '0);
  endtask

  // Random stretches that grow, shrink or mix the list, some without idling
  task automatic test_random_traffic(int n_items);
    traffic_mode_t mode;
    int stretch_left;
    logic [ACTION_BITS-1:0] act;
    stretch_left = 0;
    mode = MODE_MIXED;
    for (int n = 0; n < n_items; n++) begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       mode = MODE_GROW;
          1:       mode = MODE_SHRINK;
          default: mode = MODE_MIXED;
        endcase
        steady = ($urandom_range(0, 4) == 0);
      end
      stretch_left--;
      act = pick_action(mode);
      send_item(act, pick_position(act), pick_value());
    end
    steady = 1'b0;
  endtask

  initial begin
    error_count  = 0;
    shadow_count = 0;
    steady       = 1'b0;
    rst = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.action   = ACT_PUSH;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_rejections();
    test_edit_positions();
    test_full_boundary();
    test_random_traffic(500);

    // Hold the request side idle and let outstanding results drain
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
